### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while reset is low
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset as well
`define M3I_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared constants, types and helpers for the 3x3 cofactor inverter
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

    localparam int M3I_FRAC_BITS = 16;
    localparam int M3I_DATA_W    = 32;
    localparam int M3I_TOL_W     = 31;
    localparam int M3I_QUOT_W    = M3I_DATA_W + 1;
    localparam int M3I_DMAG_W    = 3 * M3I_DATA_W;
    localparam int M3I_NUM_W     = M3I_DMAG_W + M3I_QUOT_W + 1;

    localparam logic [M3I_DATA_W-1:0] M3I_POS_MAX = {1'b0, {(M3I_DATA_W-1){1'b1}}};
    localparam logic [M3I_DATA_W-1:0] M3I_NEG_MAG = {1'b1, {(M3I_DATA_W-1){1'b0}}};

    // element indices for each cofactor: a[0]*a[1] - a[2]*a[3]
    localparam logic [3:0] M3I_COF_IDX [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic [M3I_DATA_W-1:0] val;
        logic                  sat;
    } t_clamp;

    typedef struct packed {
        logic                       singular;
        logic                       dneg;
        logic [8:0]                 cneg;
        logic [8:0]                 ss;
        logic [8:0][M3I_DATA_W-1:0] sv;
    } t_side;

    // signed clamp of a magnitude; big means bits above the low word are set
    function automatic t_clamp m3i_clamp(input logic neg, input logic big,
                                         input logic [M3I_DATA_W-1:0] mag);
        t_clamp                r;
        logic [M3I_DATA_W-1:0] lim;
        logic [M3I_DATA_W-1:0] m;
        lim = neg ? M3I_NEG_MAG : M3I_POS_MAX;
        m = mag;
        r.sat = 1'b0;
        if (big || (mag > lim)) begin
            m = lim;
            r.sat = 1'b1;
        end
        r.val = neg ? (~m + 1'b1) : m;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/m3i_div_pipe.sv
// ----------------------------------------------------------------------------
// m3i_div_pipe
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div_pipe #(
    parameter int NUM_W  = m3i_pkg::M3I_NUM_W,
    parameter int DEN_W  = m3i_pkg::M3I_DMAG_W,
    parameter int QUOT_W = m3i_pkg::M3I_QUOT_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [QUOT_W-1:0] o_quot,
    output logic                   o_ovf
);

    logic [NUM_W-1:0]  r_rem [0:QUOT_W];
    logic [DEN_W-1:0]  r_den [0:QUOT_W];
    logic [QUOT_W-1:0] r_q   [0:QUOT_W];
    logic              r_ovf [0:QUOT_W];

    // quotient at or above 2^QUOT_W
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= i_num >= (NUM_W'(i_den) << QUOT_W);
        end
    end

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
        localparam int B = QUOT_W - k;
        logic [NUM_W:0]    n_trial;
        logic [QUOT_W-1:0] n_q;

        always_comb begin
            n_trial = {1'b0, r_rem[k-1]} - ((NUM_W+1)'(r_den[k-1]) << B);
            n_q     = r_q[k-1];
            n_q[B]  = ~n_trial[NUM_W];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_trial[NUM_W] ? r_rem[k-1] : n_trial[NUM_W-1:0];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= n_q;
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_q[QUOT_W];
    assign o_ovf  = r_ovf[QUOT_W];

endmodule

`default_nettype wire

### rtl/matrix3_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_cofactor
// pipeline: 41 register stages from the accepting edge to result valid
// throughput: one matrix per cycle while the output is not stalled; the 33-stage restoring
// divider per entry sets the depth, each stage resolving one quotient bit
// reset: synchronous active low, clears stage valid bits and tolerance
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module matrix3_inverse_cofactor #(
    parameter int FRAC_BITS = m3i_pkg::M3I_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [30:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic signed [31:0] i_a_00,
    input  wire logic signed [31:0] i_a_01,
    input  wire logic signed [31:0] i_a_02,
    input  wire logic signed [31:0] i_a_10,
    input  wire logic signed [31:0] i_a_11,
    input  wire logic signed [31:0] i_a_12,
    input  wire logic signed [31:0] i_a_20,
    input  wire logic signed [31:0] i_a_21,
    input  wire logic signed [31:0] i_a_22,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_inv_00,
    output logic signed [31:0] o_inv_01,
    output logic signed [31:0] o_inv_02,
    output logic signed [31:0] o_inv_10,
    output logic signed [31:0] o_inv_11,
    output logic signed [31:0] o_inv_12,
    output logic signed [31:0] o_inv_20,
    output logic signed [31:0] o_inv_21,
    output logic signed [31:0] o_inv_22,
    output logic             o_invertible,
    output logic             o_saturated
);

    localparam int DW    = m3i_pkg::M3I_DATA_W;
    localparam int CW    = 2 * DW;
    localparam int DMW   = m3i_pkg::M3I_DMAG_W;
    localparam int DETW  = DMW + 2;
    localparam int QW    = m3i_pkg::M3I_QUOT_W;
    localparam int NUM_W = (CW + 2 * FRAC_BITS + 1 > DMW + QW + 1) ?
                           (CW + 2 * FRAC_BITS + 1) : (DMW + QW + 1);
    localparam int SW    = CW + 1 - FRAC_BITS;
    localparam int NST   = QW + 8;

    logic                  w_en;
    logic signed [DW-1:0]  w_a [0:8];
    logic [m3i_pkg::M3I_TOL_W-1:0] r_tol;
    logic [NST-1:0]        r_vld;

    assign w_en    = ~(r_vld[NST-1] & i_stall);
    assign o_stall = r_vld[NST-1] & i_stall;
    assign o_valid = r_vld[NST-1];

    assign w_a[0] = i_a_00;
    assign w_a[1] = i_a_01;
    assign w_a[2] = i_a_02;
    assign w_a[3] = i_a_10;
    assign w_a[4] = i_a_11;
    assign w_a[5] = i_a_12;
    assign w_a[6] = i_a_20;
    assign w_a[7] = i_a_21;
    assign w_a[8] = i_a_22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], i_valid};
            end
        end
    end

    // stage 1: cofactor products
    logic signed [CW-1:0] r_s1_p [0:17];
    logic signed [DW-1:0] r_s1_a [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 9; i++) begin
                r_s1_p[2*i]   <= w_a[m3i_pkg::M3I_COF_IDX[i][0]] *
                                 w_a[m3i_pkg::M3I_COF_IDX[i][1]];
                r_s1_p[2*i+1] <= w_a[m3i_pkg::M3I_COF_IDX[i][2]] *
                                 w_a[m3i_pkg::M3I_COF_IDX[i][3]];
            end
            for (int i = 0; i < 3; i++) begin
                r_s1_a[i] <= w_a[i];
            end
        end
    end

    // stage 2: cofactors as sign and magnitude
    logic [CW-1:0]        r_cmag [2:6][0:8];
    logic [8:0]           r_cneg [2:6];
    logic signed [DW-1:0] r_s2_a [0:2];
    logic signed [CW:0]   n_diff [0:8];
    logic signed [CW:0]   n_dabs [0:8];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_diff[i] = (CW+1)'(r_s1_p[2*i]) - (CW+1)'(r_s1_p[2*i+1]);
            n_dabs[i] = n_diff[i][CW] ? -n_diff[i] : n_diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 9; i++) begin
                r_cmag[2][i] <= n_dabs[i][CW-1:0];
                r_cneg[2][i] <= n_diff[i][CW];
            end
            r_s2_a <= r_s1_a;
            // cofactor carry through stages 3 to 6
            for (int s = 3; s <= 6; s++) begin
                r_cmag[s] <= r_cmag[s-1];
                r_cneg[s] <= r_cneg[s-1];
            end
        end
    end

    // stage 3: determinant partial products, split at 32 bits
    logic [CW-1:0] r_s3_pl [0:2];
    logic [CW-1:0] r_s3_ph [0:2];
    logic [2:0]    r_s3_tneg;
    logic [DW-1:0] n_am [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_am[i] = r_s2_a[i][DW-1] ? (~r_s2_a[i] + 1'b1) : r_s2_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_pl[i]   <= n_am[i] * r_cmag[2][3*i][DW-1:0];
                r_s3_ph[i]   <= n_am[i] * r_cmag[2][3*i][CW-1:DW];
                r_s3_tneg[i] <= r_s2_a[i][DW-1] ^ r_cneg[2][3*i];
            end
        end
    end

    // stage 4: signed determinant terms
    logic signed [DETW-1:0] r_s4_t [0:2];
    logic [DMW-1:0]         n_tmag [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tmag[i] = DMW'(r_s3_pl[i]) + (DMW'(r_s3_ph[i]) << DW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_t[i] <= r_s3_tneg[i] ? -DETW'(n_tmag[i]) : DETW'(n_tmag[i]);
            end
        end
    end

    // stage 5: determinant
    logic signed [DETW-1:0] r_s5_det;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_det <= r_s4_t[0] + r_s4_t[1] + r_s4_t[2];
        end
    end

    // stage 6: determinant magnitude, rounded adjugate for the singular case
    logic                   r_s6_dneg;
    logic [DMW-1:0]         r_s6_dmag;
    logic [DW-1:0]          r_s6_sv [0:8];
    logic [8:0]             r_s6_ss;
    logic signed [DETW-1:0] n_detabs;
    logic [SW-1:0]          n_sm [0:8];
    m3i_pkg::t_clamp        n_sc [0:8];

    always_comb begin
        n_detabs = r_s5_det[DETW-1] ? -r_s5_det : r_s5_det;
        for (int i = 0; i < 9; i++) begin
            n_sm[i] = SW'(((CW+1)'(r_cmag[5][i]) + ((CW+1)'(1) << (FRAC_BITS - 1)))
                      >> FRAC_BITS);
            n_sc[i] = m3i_pkg::m3i_clamp(r_cneg[5][i], |n_sm[i][SW-1:DW], n_sm[i][DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_dneg <= r_s5_det[DETW-1];
            r_s6_dmag <= n_detabs[DMW-1:0];
            for (int i = 0; i < 9; i++) begin
                r_s6_sv[i] <= n_sc[i].val;
                r_s6_ss[i] <= n_sc[i].sat;
            end
        end
    end

    // stage 7 onward: dividers and side data
    logic [NUM_W-1:0] w_num  [0:8];
    logic [QW-1:0]    w_quot [0:8];
    logic [8:0]       w_ovf;

    for (genvar i = 0; i < 9; i++) begin : g_div
        assign w_num[i] = NUM_W'(r_cmag[6][i]) << (2 * FRAC_BITS + 1);

        m3i_div_pipe #(
            .NUM_W  (NUM_W),
            .DEN_W  (DMW),
            .QUOT_W (QW)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_num[i]),
            .i_den  (r_s6_dmag),
            .o_quot (w_quot[i]),
            .o_ovf  (w_ovf[i])
        );
    end

    m3i_pkg::t_side r_sb [0:QW];
    logic [DMW-1:0] w_lim;

    assign w_lim = DMW'(r_tol) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0].singular <= r_s6_dmag <= w_lim;
            r_sb[0].dneg     <= r_s6_dneg;
            r_sb[0].cneg     <= r_cneg[6];
            r_sb[0].ss       <= r_s6_ss;
            for (int i = 0; i < 9; i++) begin
                r_sb[0].sv[i] <= r_s6_sv[i];
            end
            for (int k = 1; k <= QW; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // output stage: rounding, selection and clamp
    logic [DW-1:0] r_out_inv [0:8];
    logic          r_out_invertible;
    logic          r_out_saturated;
    logic [DW-1:0] n_inv [0:8];
    logic          n_sat;

    always_comb begin
        logic [QW:0]     qp;
        m3i_pkg::t_clamp c;
        n_sat = 1'b0;
        for (int i = 0; i < 9; i++) begin
            qp = {1'b0, w_quot[i]} + 1'b1;
            if (r_sb[QW].singular) begin
                c.val = r_sb[QW].sv[i];
                c.sat = r_sb[QW].ss[i];
            end else begin
                c = m3i_pkg::m3i_clamp(r_sb[QW].cneg[i] ^ r_sb[QW].dneg,
                                       w_ovf[i] | qp[QW], qp[DW:1]);
            end
            n_inv[i] = c.val;
            n_sat    = n_sat | c.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_inv        <= n_inv;
            r_out_invertible <= ~r_sb[QW].singular;
            r_out_saturated  <= n_sat;
        end
    end

    assign o_inv_00     = r_out_inv[0];
    assign o_inv_01     = r_out_inv[1];
    assign o_inv_02     = r_out_inv[2];
    assign o_inv_10     = r_out_inv[3];
    assign o_inv_11     = r_out_inv[4];
    assign o_inv_12     = r_out_inv[5];
    assign o_inv_20     = r_out_inv[6];
    assign o_inv_21     = r_out_inv[7];
    assign o_inv_22     = r_out_inv[8];
    assign o_invertible = r_out_invertible;
    assign o_saturated  = r_out_saturated;

    `M3I_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, r_vld == '0,
        "pipe not empty after reset")
    `M3I_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, !o_stall,
        r_vld == $past({r_vld[NST-2:0], i_valid}), "valid bits did not advance")
    `M3I_ASSERT_NEXT(a_vld_hold, i_clk, i_rst_n, o_stall,
        r_vld == $past(r_vld), "valid bits moved under stall")

endmodule

`default_nettype wire
